// ----- rtl/i2c_bseq_pkg.sv -----
package i2c_bseq_pkg;

	// command kinds carried by a request
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_STOP  = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;
	localparam logic [2:0] KIND_CTRL  = 3'd5;

	// configuration register indexes
	localparam logic REG_BLOCK_BITS  = 1'b0;
	localparam logic REG_BLOCK_SHIFT = 1'b1;

	// control byte bases
	localparam logic [7:0] CTRL_WRITE_BASE = 8'hA0;
	localparam logic [7:0] CTRL_READ_BASE  = 8'hA1;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_START,
		OP_STOP,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [18:0] address;
		logic        read_not_write;
		logic        ack_level;
		logic        sda_in;
	} in_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_ok;
		logic [7:0] read_byte;
	} out_t;

	typedef struct packed {
		logic [4:0] phase;
		op_t        op;
		logic [7:0] shift_byte;
		logic       ack_latch;
		logic       lv_clk;
		logic       lv_data;
		logic       lv_drive;
	} state_t;

endpackage

// ----- rtl/i2c_bseq_core.sv -----
module i2c_bseq_core (
	input  i2c_bseq_pkg::state_t st,
	input  i2c_bseq_pkg::in_t    item,
	input  logic [1:0]           block_bits,
	input  logic [4:0]           block_shift,
	output i2c_bseq_pkg::state_t nxt,
	output i2c_bseq_pkg::out_t   res
);

	logic [18:0] blk;
	logic [7:0]  ctrl_byte;

	// control byte: block number bits run down from bit 3, top bit of the field at bit 3
	always_comb begin
		blk = item.address >> block_shift;
		ctrl_byte = item.read_not_write ? i2c_bseq_pkg::CTRL_READ_BASE
		                                : i2c_bseq_pkg::CTRL_WRITE_BASE;
		case (block_bits)
			2'd1: ctrl_byte[3]   = blk[0];
			2'd2: ctrl_byte[3:2] = blk[1:0];
			2'd3: ctrl_byte[3:1] = blk[2:0];
			default: ;
		endcase
	end

	always_comb begin
		logic [4:0] p;
		logic [4:0] pm1;
		logic [8:0] prod;
		logic [2:0] q;
		logic [4:0] sub;
		logic       done;

		nxt  = st;
		res  = '0;
		done = 1'b0;
		p    = '0;
		pm1  = '0;
		prod = '0;
		q    = '0;
		sub  = '0;

		if (st.op == i2c_bseq_pkg::OP_IDLE) begin
			case (item.kind)
				i2c_bseq_pkg::KIND_START: begin
					nxt.phase = '0;
					nxt.op    = i2c_bseq_pkg::OP_START;
				end
				i2c_bseq_pkg::KIND_STOP: begin
					nxt.phase = '0;
					nxt.op    = i2c_bseq_pkg::OP_STOP;
				end
				i2c_bseq_pkg::KIND_WRITE: begin
					nxt.phase      = '0;
					nxt.op         = i2c_bseq_pkg::OP_WRITE;
					nxt.shift_byte = item.value;
				end
				i2c_bseq_pkg::KIND_READ: begin
					nxt.phase      = '0;
					nxt.op         = i2c_bseq_pkg::OP_READ;
					nxt.shift_byte = '0;
					nxt.ack_latch  = item.ack_level;
				end
				i2c_bseq_pkg::KIND_CTRL: begin
					nxt.phase      = '0;
					nxt.op         = i2c_bseq_pkg::OP_WRITE;
					nxt.shift_byte = ctrl_byte;
				end
				default: ;
			endcase
		end

		if (nxt.op != i2c_bseq_pkg::OP_IDLE) begin
			p = nxt.phase;
			res.busy_res = 1'b1;
			case (nxt.op)
				i2c_bseq_pkg::OP_START: begin
					nxt.lv_clk   = p[0] ^ p[1];
					nxt.lv_data  = ~p[1];
					nxt.lv_drive = 1'b1;
					done = (p >= 5'd3);
				end
				i2c_bseq_pkg::OP_STOP: begin
					nxt.lv_clk   = p[0] ^ p[1];
					nxt.lv_data  = p[1];
					nxt.lv_drive = 1'b1;
					done = (p >= 5'd3);
				end
				i2c_bseq_pkg::OP_WRITE: begin
					// three ticks per bit: (p-1)/3 by multiply by 11, shift by 5
					pm1  = p - 5'd1;
					prod = {4'b0, pm1} * 9'd11;
					q    = prod[7:5];
					sub  = pm1 - {1'b0, q, 1'b0} - {2'b0, q};
					if (p == 5'd0) begin
						nxt.lv_clk   = 1'b0;
						nxt.lv_data  = 1'b0;
						nxt.lv_drive = 1'b1;
					end else if (p <= 5'd24) begin
						nxt.lv_clk   = (sub == 5'd1);
						nxt.lv_data  = nxt.shift_byte[3'd7 - q];
						nxt.lv_drive = 1'b1;
					end else if (p == 5'd25) begin
						nxt.lv_clk   = 1'b0;
						nxt.lv_data  = 1'b1;
						nxt.lv_drive = 1'b0;
					end else if (p == 5'd26) begin
						nxt.lv_clk   = 1'b1;
						nxt.lv_data  = 1'b1;
						nxt.lv_drive = 1'b0;
					end else begin
						nxt.lv_clk    = 1'b0;
						nxt.lv_data   = 1'b1;
						nxt.lv_drive  = 1'b1;
						nxt.ack_latch = item.sda_in;
						res.ack_ok    = ~item.sda_in;
						done = 1'b1;
					end
				end
				i2c_bseq_pkg::OP_READ: begin
					if (p <= 5'd16) begin
						nxt.lv_clk   = p[0];
						nxt.lv_data  = 1'b1;
						nxt.lv_drive = 1'b0;
						if (p >= 5'd2 && !p[0])
							nxt.shift_byte = {nxt.shift_byte[6:0], item.sda_in};
					end else begin
						nxt.lv_clk   = (p == 5'd18);
						nxt.lv_data  = nxt.ack_latch;
						nxt.lv_drive = 1'b1;
						if (p >= 5'd19) begin
							done = 1'b1;
							res.read_byte = nxt.shift_byte;
						end
					end
				end
				default: ;
			endcase
			if (done) begin
				nxt.op    = i2c_bseq_pkg::OP_IDLE;
				nxt.phase = '0;
			end else begin
				nxt.phase = p + 5'd1;
			end
		end

		res.done_res  = done;
		res.scl       = nxt.lv_clk;
		res.sda_out   = nxt.lv_data;
		res.sda_drive = nxt.lv_drive;
	end

endmodule

// ----- rtl/i2c_eeprom_bit_sequencer_unit.sv -----
// I2C master bit sequencer for 24xx EEPROMs. Every request is one bus tick:
// it carries a command kind, its operands and the sampled data line, and
// yields exactly one result with the clock / data levels for that tick plus
// busy, done, ack and read byte. An idle sequencer starts a command on the
// tick that brings it; commands that arrive while busy are dropped and the
// running command keeps advancing. Start and stop take 4 ticks, a byte or
// control-byte write 28 ticks, a byte read 20 ticks. Throughput is one
// request per clock while out_stall is low; a request passes the request
// register, then result register, with one sequencing pass between them.
// Config writes (block_bits, block_shift) are always ready and must only be
// issued while no request is in flight.
module i2c_eeprom_bit_sequencer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  i2c_bseq_pkg::in_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output i2c_bseq_pkg::out_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data
);

	// config registers
	logic [1:0] block_bits_q;
	logic [4:0] block_shift_q;

	// sequencer state
	i2c_bseq_pkg::state_t st_q;
	i2c_bseq_pkg::state_t st_nxt;

	// request register
	logic              req_v_s1;
	i2c_bseq_pkg::in_t req_s1;

	// result register
	logic               res_v_q;
	i2c_bseq_pkg::out_t res_q;
	i2c_bseq_pkg::out_t res_nxt;

	logic res_free;
	logic advance;
	logic in_take;

	// result slot frees when empty or being drained this cycle
	assign res_free = !res_v_q || !out_stall;
	// request in stage 1 moves on (and commits its state) when the slot frees
	assign advance  = req_v_s1 && res_free;
	// stage 1 takes a new request when empty or emptying
	assign in_stall = req_v_s1 && !res_free;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;
	assign out_valid = res_v_q;
	assign out_data  = res_q;

	i2c_bseq_core u_core (
		.st          (st_q),
		.item        (req_s1),
		.block_bits  (block_bits_q),
		.block_shift (block_shift_q),
		.nxt         (st_nxt),
		.res         (res_nxt)
	);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bits_q  <= 2'd0;
			block_shift_q <= 5'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2c_bseq_pkg::REG_BLOCK_BITS:  block_bits_q  <= cfg_data[1:0];
				i2c_bseq_pkg::REG_BLOCK_SHIFT: block_shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state: reset is idle, clock low, data high and driven
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= '0;
			st_q.op         <= i2c_bseq_pkg::OP_IDLE;
			st_q.shift_byte <= '0;
			st_q.ack_latch  <= 1'b1;
			st_q.lv_clk     <= 1'b0;
			st_q.lv_data    <= 1'b1;
			st_q.lv_drive   <= 1'b1;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (in_take)
				req_v_s1 <= 1'b1;
			else if (advance)
				req_v_s1 <= 1'b0;
			if (advance)
				res_v_q <= 1'b1;
			else if (!out_stall)
				res_v_q <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_take)
			req_s1 <= in_data;
		if (advance)
			res_q <= res_nxt;
	end

endmodule
